>>> sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define GGT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// clocked assertion that also holds through reset
`define GGT_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ggt_pkg.sv
// constants shared by the geglu gate unit
// no dependencies
package ggt_pkg;

    localparam int GGT_FRAC_BITS     = 11;
    localparam int GGT_TANH_SEGMENTS = 256;

    // sqrt(2/pi) in q16 and the cubic coefficient in q20
    localparam int unsigned GK_Q16  = 52290;
    localparam int unsigned GC_Q20  = 46887;
    localparam int unsigned ONE_Q15 = 32768;

endpackage

>>> sv/ggt_in_if.sv
// input channel of the geglu gate unit: one (gate, up) pair per transaction
// no dependencies
interface ggt_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] gate;
    logic signed [15:0] up;
    logic               last_in;

    modport source (output valid, output gate, output up, output last_in, input ready);
    modport sink   (input valid, input gate, input up, input last_in, output ready);
endinterface

>>> sv/ggt_out_if.sv
// output channel of the geglu gate unit: one product per transaction
// no dependencies
interface ggt_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] product;
    logic               last_out;

    modport source (output valid, output product, output last_out, input ready);
    modport sink   (input valid, input product, input last_out, output ready);
endinterface

>>> sv/ggt_tanh_lut.sv
// tanh of a nonnegative q(frac+16) argument, q15 result, three register stages
// table built at elaboration; depends on ggt_pkg
module ggt_tanh_lut import ggt_pkg::*; #(
    parameter int FRAC_BITS     = GGT_FRAC_BITS,
    parameter int TANH_SEGMENTS = GGT_TANH_SEGMENTS
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [FRAC_BITS+18:0]  i_u,
    output logic [15:0]            o_t
);

    localparam int L_W   = FRAC_BITS + 18;
    localparam int IDX_W = $clog2(TANH_SEGMENTS + 1);
    localparam int Q_W   = L_W + IDX_W;
    localparam int M_W   = L_W + 16;

    typedef logic [TANH_SEGMENTS:0][15:0] t_tab;

    // shift and subtract division, only used while elaborating the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[62:0], num[j]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[j] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh(4*i/segments) in q15 from an integer recurrence on exp(-8/segments)
    function automatic t_tab build_tab();
        t_tab        tab;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic [63:0] b;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] q;
        pos  = '0;
        neg  = '0;
        term = 64'd1 << 40;
        for (int k = 0; k < 40; k++) begin
            if (k % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
            term = udiv64(term * 64'd8, 64'(TANH_SEGMENTS) * 64'(k + 1));
        end
        b = ((pos - neg) + (64'd1 << 9)) >> 10;
        e = 64'd1 << 30;
        for (int i = 0; i <= TANH_SEGMENTS; i++) begin
            den    = (64'd1 << 30) + e;
            num    = (((64'd1 << 30) - e) << 15) + (den >> 1);
            q      = udiv64(num, den);
            tab[i] = q[15:0];
            e      = (e * b + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

    localparam t_tab TANH_TAB = build_tab();

    logic [Q_W-1:0]   n_q;
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] n_idx_hi;

    logic [15:0]      r_lo;
    logic [15:0]      r_hi;
    logic [L_W-1:0]   r_f;
    logic             r_sat;
    logic [M_W-1:0]   r_m;
    logic [15:0]      r_lo2;
    logic             r_sat2;
    logic [15:0]      n_t;
    logic [15:0]      r_t;

    always_comb begin
        n_q      = Q_W'(i_u[L_W-1:0]) * Q_W'(TANH_SEGMENTS);
        n_idx    = n_q[Q_W-1 -: IDX_W];
        n_idx_hi = n_idx + IDX_W'(1);
    end

    always_comb begin
        if (r_sat2) begin
            n_t = 16'(ONE_Q15);
        end else begin
            n_t = r_lo2 + 16'((r_m + (M_W'(1) << (L_W - 1))) >> L_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // table read, argument of four or more saturates
            r_lo   <= TANH_TAB[n_idx];
            r_hi   <= TANH_TAB[n_idx_hi];
            r_f    <= n_q[L_W-1:0];
            r_sat  <= i_u[L_W];
            // interpolation weight
            r_m    <= M_W'(r_hi - r_lo) * M_W'(r_f);
            r_lo2  <= r_lo;
            r_sat2 <= r_sat;
            r_t    <= n_t;
        end
    end

    assign o_t = r_t;

endmodule

>>> sv/geglu_tanh_gate_unit.sv
// geglu gate unit: product = gelu(gate) * up in signed fixed point
// depends on ggt_pkg, ggt_in_if, ggt_out_if and ggt_tanh_lut
//
// usage:
//   i_in carries (gate, up, last_in), o_out carries (product, last_out), both
//   valid/ready; a transaction happens on a clock edge with valid and ready high.
//   gate, up and product are signed 16-bit values with FRAC_BITS fraction bits.
//   product is rounded to nearest (halves away from zero) and saturated.
//   last_out is last_in of the same element.
// timing:
//   11 register stages from input transaction to o_out.valid; one element per
//   cycle when not stalled. stages: input, cube term (two multiplier stages),
//   clamp, scaling, tanh table read and interpolation, two products, output.
// stall:
//   all stages advance together whenever the output register is empty or being
//   taken; while the receiver holds o_out.ready low with a result waiting,
//   i_in.ready is low and every stage holds, so nothing is dropped or repeated.
// reset:
//   i_rst_n is synchronous, active low, and clears all valid bits; there is no
//   clearing pass, the tanh table is a constant.
module geglu_tanh_gate_unit import ggt_pkg::*; #(
    parameter int FRAC_BITS     = GGT_FRAC_BITS,
    parameter int TANH_SEGMENTS = GGT_TANH_SEGMENTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ggt_in_if.sink    i_in,
    ggt_out_if.source o_out
);

    localparam int NSTG    = 11;
    localparam int CUBE_SH = 2 * FRAC_BITS + 20;
    localparam int S_W     = FRAC_BITS + 3;
    localparam int U_W     = FRAC_BITS + 19;
    localparam int P1_W    = 32;
    localparam int P_W     = 47;
    localparam int MAG_W   = P_W - FRAC_BITS - 16;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] r;
        logic        gneg;
        logic        pneg;
        logic        last;
    } t_side;

    logic            en;
    logic [NSTG-1:0] r_vld;
    t_side           r_side [0:NSTG-2];
    t_side           n_side;

    logic [31:0]     r_aa;
    logic [31:0]     r_ac;
    logic [63:0]     r_raw;
    logic [63:0]     n_s_full;
    logic [S_W-1:0]  n_s;
    logic [S_W-1:0]  r_s;
    logic [U_W-1:0]  r_u;
    logic [15:0]     tanh_t;
    logic [16:0]     n_w;
    logic [P1_W-1:0] r_p1;
    logic [P_W-1:0]  r_p;
    logic [MAG_W-1:0] n_mag;
    logic [15:0]     n_prod;
    logic [15:0]     r_prod;
    logic            r_last;

    assign en         = !r_vld[NSTG-1] || o_out.ready;
    assign i_in.ready = en;

    always_comb begin
        n_side.gneg = i_in.gate[15];
        n_side.pneg = i_in.gate[15] ^ i_in.up[15];
        n_side.last = i_in.last_in;
        n_side.a    = i_in.gate[15] ? 16'(~i_in.gate + 16'sd1) : 16'(i_in.gate);
        n_side.r    = i_in.up[15] ? 16'(~i_in.up + 16'sd1) : 16'(i_in.up);
    end

    // cube term rounding; anything at 8.0 or above saturates tanh, so clamp
    always_comb begin
        n_s_full = 64'(r_side[2].a) +
                   ((r_raw + (64'd1 << (CUBE_SH - 1))) >> CUBE_SH);
        if (n_s_full >= (64'd1 << S_W)) begin
            n_s = {S_W{1'b1}};
        end else begin
            n_s = n_s_full[S_W-1:0];
        end
    end

    always_comb begin
        if (r_side[7].gneg) begin
            n_w = 17'(ONE_Q15) - {1'b0, tanh_t};
        end else begin
            n_w = 17'(ONE_Q15) + {1'b0, tanh_t};
        end
    end

    always_comb begin
        n_mag = MAG_W'((r_p + (P_W'(1) << (FRAC_BITS + 15))) >> (FRAC_BITS + 16));
        if (n_mag == '0) begin
            n_prod = '0;
        end else if (r_side[9].pneg) begin
            if (n_mag >= MAG_W'(32768)) begin
                n_prod = 16'h8000;
            end else begin
                n_prod = 16'(~n_mag[15:0] + 16'd1);
            end
        end else begin
            if (n_mag > MAG_W'(32767)) begin
                n_prod = 16'h7fff;
            end else begin
                n_prod = n_mag[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < NSTG - 1; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_aa   <= 32'(r_side[0].a) * 32'(r_side[0].a);
            r_ac   <= 32'(r_side[0].a) * 32'(GC_Q20);
            r_raw  <= 64'(r_aa) * 64'(r_ac);
            r_s    <= n_s;
            r_u    <= U_W'(r_s) * U_W'(GK_Q16);
            r_p1   <= P1_W'(r_side[7].a) * P1_W'(n_w);
            r_p    <= P_W'(r_p1) * P_W'(r_side[8].r);
            r_prod <= n_prod;
            r_last <= r_side[9].last;
        end
    end

    ggt_tanh_lut #(
        .FRAC_BITS     (FRAC_BITS),
        .TANH_SEGMENTS (TANH_SEGMENTS)
    ) u_tanh (
        .i_clk (i_clk),
        .i_en  (en),
        .i_u   (r_u),
        .o_t   (tanh_t)
    );

    assign o_out.valid    = r_vld[NSTG-1];
    assign o_out.product  = r_prod;
    assign o_out.last_out = r_last;

endmodule

>>> sv/ggt_checker.sv
// port-level checks for the geglu gate unit, attached by bind
// depends on assert_macros.svh, ggt_in_if and ggt_out_if
`include "assert_macros.svh"

module ggt_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ggt_in_if.sink    i_in,
    ggt_out_if.source o_out
);

    `GGT_ASSERT_NR(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out.valid, "output valid after reset")

    `GGT_ASSERT(a_stall_blocks_in, i_clk, i_rst_n, o_out.valid && !o_out.ready |-> !i_in.ready, "input taken while output stalled")

    `GGT_ASSERT(a_empty_takes_in, i_clk, i_rst_n, !o_out.valid |-> i_in.ready, "input refused with output register empty")

    `GGT_ASSERT(a_out_holds, i_clk, i_rst_n, o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.product) && $stable(o_out.last_out), "stalled result changed")

endmodule

bind geglu_tanh_gate_unit ggt_checker u_ggt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);
